>>> hw/rtl/assert_macros.svh
// Assertion macros used by the residual filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk while arst_n is released.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds on a rising edge of clk.
`define ASSERT_NEVER(lbl, cond, msg) \
	`ASSERT_CLK(lbl, !(cond), msg)

`endif

>>> hw/rtl/rdf_pkg.sv
// Shared types and constants of the residual filter.
package rdf_pkg;

	// Default number of lag taps held in hardware.
	localparam int MAX_ORDER_DEF = 8;

	// Field and datapath widths.
	localparam int VALUE_W     = 32;
	localparam int SLOT_W      = 5;
	localparam int CFG_ORDER_W = 4;
	localparam int ACC_W       = 64;
	localparam int FRAC_W      = 16;
	localparam int QUO_W       = 33;
	localparam int SAT_SH      = QUO_W - FRAC_W;
	localparam int DIV_CNT_W   = $clog2(QUO_W + 1);

	// Configuration port.
	localparam int PADDR_W         = 2;
	localparam int PDATA_W         = 32;
	localparam int REG_MODEL_ORDER = 0;
	localparam logic [CFG_ORDER_W-1:0] ORDER_RESET = 4'd1;

	// Input queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Saturation limits of the Q16.16 result.
	localparam logic [QUO_W-1:0]   LIM_POS     = 33'h0_7FFF_FFFF;
	localparam logic [QUO_W-1:0]   LIM_NEG     = 33'h0_8000_0000;
	localparam logic [VALUE_W-1:0] RES_POS_MAX = 32'h7FFF_FFFF;
	localparam logic [VALUE_W-1:0] RES_NEG_MAX = 32'h8000_0000;

	// One classified input beat as it waits in the queue.
	typedef struct packed {
		logic                      is_sample;
		logic                      wr_mean;
		logic                      wr_const;
		logic                      wr_scale;
		logic [SLOT_W-1:0]         idx;
		logic signed [VALUE_W-1:0] value;
	} item_t;

	// Queue status seen by the top level.
	typedef struct packed {
		logic [QCNT_W-1:0] count;
	} front_stat_t;

	// Divider request and response.
	typedef struct packed {
		logic             start;
		logic [ACC_W-1:0] mag;
		logic [ACC_W-1:0] scale;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

	// Sequencer states of the back end.
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MAC,
		BK_DRAIN,
		BK_NUMER,
		BK_RANGE,
		BK_DIV,
		BK_FINISH,
		BK_EMIT
	} back_state_t;

endpackage

>>> hw/rtl/ldar_residual_filter_core.sv
// Top level of the linear double autoregression residual filter.
// Items enter through a two-beat queue, so a coefficient word or sample can be pushed while
// the engine is busy. A coefficient word is written in the idle state and gives no result.
// A warm-up sample goes from the idle state straight to the emit state. A full sample runs
// the multiply-accumulate over its lags, then the numerator and range check, and then the
// one-bit-per-cycle divider, which sets the rate. A sample with a bad scale or an
// out-of-range quotient skips the divider. Results wait in an output register, so the
// engine finishes the next item while a result stays unread; model_order sits at byte
// address 0 of the APB port and may only be written while the block is idle.
`include "assert_macros.svh"

module ldar_residual_filter_core #(
	parameter int MAX_ORDER = rdf_pkg::MAX_ORDER_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input queue side.
	input  logic                               push,
	output logic                               full,
	input  logic                               kind,
	input  logic [rdf_pkg::SLOT_W-1:0]         coef_slot,
	input  logic signed [rdf_pkg::VALUE_W-1:0] value,
	// Result queue side.
	output logic                               empty,
	input  logic                               pop,
	output logic signed [rdf_pkg::VALUE_W-1:0] residual,
	output logic                               warming_up,
	output logic                               bad_scale,
	output logic                               saturated,
	// Configuration port.
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [rdf_pkg::PADDR_W-1:0]        paddr,
	input  logic [rdf_pkg::PDATA_W-1:0]        pwdata,
	output logic [rdf_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready
);
	import rdf_pkg::*;

	localparam int ORD_W = $clog2(MAX_ORDER + 1);
	localparam int CMP_W = (ORD_W > CFG_ORDER_W) ? ORD_W : CFG_ORDER_W;

	logic [CFG_ORDER_W-1:0] model_order_q;
	logic [CMP_W-1:0]       ord_ext;
	logic [ORD_W-1:0]       order;
	logic                   reg_hit;
	item_t                  head;
	logic                   head_vld;
	logic                   head_pop;
	front_stat_t            fstat;
	div_req_t               div_req;
	div_rsp_t               div_rsp;

	// Register decode; the port never waits.
	assign pready  = 1'b1;
	assign reg_hit = ((paddr >> 2) == PADDR_W'(REG_MODEL_ORDER));
	assign prdata  = reg_hit ? PDATA_W'(model_order_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_order_q <= ORDER_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			model_order_q <= pwdata[CFG_ORDER_W-1:0];
		end
	end

	// An order of zero acts as one, and one above the tap count acts as the tap count.
	always_comb begin
		ord_ext = CMP_W'(model_order_q);
		if (ord_ext == '0) begin
			order = ORD_W'(1);
		end else if (ord_ext > CMP_W'(MAX_ORDER)) begin
			order = ORD_W'(MAX_ORDER);
		end else begin
			order = ord_ext[ORD_W-1:0];
		end
	end

	rdf_front #(
		.MAX_ORDER(MAX_ORDER)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.kind     (kind),
		.coef_slot(coef_slot),
		.value    (value),
		.head     (head),
		.head_vld (head_vld),
		.head_pop (head_pop),
		.stat     (fstat)
	);

	rdf_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	rdf_back #(
		.MAX_ORDER(MAX_ORDER)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_vld  (head_vld),
		.head_pop  (head_pop),
		.order     (order),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.empty     (empty),
		.pop       (pop),
		.residual  (residual),
		.warming_up(warming_up),
		.bad_scale (bad_scale),
		.saturated (saturated)
	);

	// The divider is never started while it is still working.
	`ASSERT_NEVER(a_div_start_busy, div_req.start && div_rsp.busy, "divider restarted while busy")
	// A warm-up or bad-scale result is zero and unsaturated, and the two never come together.
	`ASSERT_NEVER(a_flag_result, !empty && (warming_up || bad_scale) && ((residual != '0) || saturated || (warming_up && bad_scale)), "flagged result carries data")
	// An accepted beat leaves the queue non-empty on the next cycle.
	`ASSERT_CLK(a_push_lands, push && !full |=> fstat.count != '0, "accepted beat lost in queue")

endmodule

>>> hw/rtl/rdf_front.sv
// Front end: classifies input beats and holds them in a short queue.
module rdf_front #(
	parameter int MAX_ORDER = rdf_pkg::MAX_ORDER_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              kind,
	input  logic [rdf_pkg::SLOT_W-1:0]        coef_slot,
	input  logic signed [rdf_pkg::VALUE_W-1:0] value,
	output rdf_pkg::item_t                    head,
	output logic                              head_vld,
	input  logic                              head_pop,
	output rdf_pkg::front_stat_t              stat
);
	import rdf_pkg::*;

	item_t             ent_q [QUEUE_DEPTH];
	item_t             cls;
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	// Sort a beat into a sample or a write to one of the three coefficient banks, or to none.
	always_comb begin
		cls           = '0;
		cls.is_sample = kind;
		cls.wr_mean   = !kind && (int'(coef_slot) < MAX_ORDER);
		cls.wr_const  = !kind && (int'(coef_slot) == MAX_ORDER);
		cls.wr_scale  = !kind && (int'(coef_slot) > MAX_ORDER) &&
			(int'(coef_slot) <= 2 * MAX_ORDER);
		cls.idx       = cls.wr_scale ? (coef_slot - SLOT_W'(MAX_ORDER + 1)) : coef_slot;
		cls.value     = value;
	end

	assign full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head_vld = (cnt_q != '0);
	assign head     = ent_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = head_pop && head_vld;
	assign stat.count = cnt_q;

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Queue entries.
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

endmodule

>>> hw/rtl/rdf_div.sv
// Restoring divider that gives the Q16.16 quotient one bit per cycle.
module rdf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rdf_pkg::div_req_t req,
	output rdf_pkg::div_rsp_t rsp
);
	import rdf_pkg::*;

	logic [ACC_W-1:0]     rem_q;
	logic [ACC_W-1:0]     dsor_q;
	logic [QUO_W-1:0]     dd_q;
	logic [QUO_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [ACC_W-1:0]     trial;
	logic                 fits;

	// Shift the next dividend bit in and try to subtract the divisor.
	assign trial = {rem_q[ACC_W-2:0], dd_q[QUO_W-1]};
	assign fits  = (trial >= dsor_q);

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder, dividend bits and quotient.
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			// The dividend is mag * 2^16; its bits above the quotient width seed the remainder.
			rem_q  <= req.mag >> SAT_SH;
			dd_q   <= {req.mag[SAT_SH-1:0], FRAC_W'(0)};
			dsor_q <= req.scale;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - dsor_q) : trial;
			dd_q  <= {dd_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

endmodule

>>> hw/rtl/rdf_back.sv
// Back end: coefficient table, lag history, tap sums and result register.
module rdf_back #(
	parameter int MAX_ORDER = rdf_pkg::MAX_ORDER_DEF,
	localparam int ORD_W = $clog2(MAX_ORDER + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rdf_pkg::item_t                     head,
	input  logic                               head_vld,
	output logic                               head_pop,
	input  logic [ORD_W-1:0]                   order,
	output rdf_pkg::div_req_t                  div_req,
	input  rdf_pkg::div_rsp_t                  div_rsp,
	output logic                               empty,
	input  logic                               pop,
	output logic signed [rdf_pkg::VALUE_W-1:0] residual,
	output logic                               warming_up,
	output logic                               bad_scale,
	output logic                               saturated
);
	import rdf_pkg::*;

	localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

	back_state_t state_q, state_d;

	logic signed [VALUE_W-1:0] mean_w_q  [MAX_ORDER];
	logic signed [VALUE_W-1:0] scale_w_q [MAX_ORDER];
	logic signed [VALUE_W-1:0] lag_q     [MAX_ORDER];
	logic signed [VALUE_W-1:0] const_q;
	logic [ORD_W-1:0]          seen_q;
	logic [IDX_W-1:0]          k_q;

	logic signed [VALUE_W-1:0] x_q;
	logic signed [ACC_W-1:0]   macc_q;
	logic signed [ACC_W-1:0]   sacc_q;
	logic                      neg_q;
	logic [ACC_W-1:0]          mag_q;

	logic                      prod_vld_s1;
	logic signed [ACC_W-1:0]   mprod_s1;
	logic signed [ACC_W-1:0]   sprod_s1;

	logic [VALUE_W-1:0]        res_val_q;
	logic                      res_warm_q;
	logic                      res_bad_q;
	logic                      res_sat_q;

	logic                      out_vld_q;
	logic [VALUE_W-1:0]        out_res_q;
	logic                      out_warm_q;
	logic                      out_bad_q;
	logic                      out_sat_q;

	logic signed [VALUE_W-1:0] lag_sel;
	logic signed [VALUE_W:0]   lag_x;
	logic [VALUE_W:0]          abs_sel;
	logic signed [ACC_W-1:0]   mprod;
	logic signed [ACC_W:0]     sprod;
	logic                      last_tap;
	logic                      warm;
	logic                      scale_bad;
	logic signed [ACC_W-1:0]   num;
	logic [ACC_W+SAT_SH-1:0]   range_lhs;
	logic [ACC_W+SAT_SH-1:0]   range_rhs;
	logic                      too_big;
	logic [QUO_W-1:0]          limit;
	logic                      out_free;

	// Products of the current tap; the absolute lag needs one extra bit.
	assign lag_sel  = lag_q[k_q];
	assign lag_x    = (VALUE_W + 1)'(lag_sel);
	assign abs_sel  = lag_x[VALUE_W] ? (VALUE_W + 1)'(-lag_x) : lag_x;
	assign mprod    = ACC_W'(mean_w_q[k_q]) * ACC_W'(lag_sel);
	assign sprod    = (ACC_W + 1)'(scale_w_q[k_q]) * $signed((ACC_W + 1)'(abs_sel));
	assign last_tap = (ORD_W'(k_q) == order - ORD_W'(1));

	// Decisions of the sample path.
	assign warm      = (seen_q < order);
	assign scale_bad = (sacc_q <= 0);
	assign num       = ACC_W'(x_q) - macc_q;
	assign range_lhs = (ACC_W + SAT_SH)'(mag_q);
	assign range_rhs = {sacc_q, SAT_SH'(0)};
	assign too_big   = (range_lhs >= range_rhs);
	assign limit     = neg_q ? LIM_NEG : LIM_POS;
	assign out_free  = !out_vld_q || pop;

	// Divider request.
	assign div_req.start = (state_q == BK_RANGE) && !too_big;
	assign div_req.mag   = mag_q;
	assign div_req.scale = sacc_q;

	// Result port.
	assign empty      = !out_vld_q;
	assign residual   = out_res_q;
	assign warming_up = out_warm_q;
	assign bad_scale  = out_bad_q;
	assign saturated  = out_sat_q;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and queue pop.
	always_comb begin
		state_d  = state_q;
		head_pop = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (head_vld) begin
					head_pop = 1'b1;
					if (head.is_sample) begin
						state_d = warm ? BK_EMIT : BK_MAC;
					end
				end
			end
			BK_MAC: begin
				if (last_tap) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				state_d = BK_NUMER;
			end
			BK_NUMER: begin
				state_d = scale_bad ? BK_EMIT : BK_RANGE;
			end
			BK_RANGE: begin
				state_d = too_big ? BK_EMIT : BK_DIV;
			end
			BK_DIV: begin
				if (div_rsp.done) begin
					state_d = BK_FINISH;
				end
			end
			BK_FINISH: begin
				state_d = BK_EMIT;
			end
			BK_EMIT: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Coefficient banks, lag history and sample count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ORDER; i++) begin
				mean_w_q[i]  <= '0;
				scale_w_q[i] <= '0;
				lag_q[i]     <= '0;
			end
			const_q <= '0;
			seen_q  <= '0;
		end else begin
			if (state_q == BK_IDLE && head_vld && !head.is_sample) begin
				if (head.wr_mean) begin
					mean_w_q[head.idx[IDX_W-1:0]] <= head.value;
				end
				if (head.wr_scale) begin
					scale_w_q[head.idx[IDX_W-1:0]] <= head.value;
				end
				if (head.wr_const) begin
					const_q <= head.value;
				end
			end
			// Every sample enters the history once its result is handed on.
			if (state_q == BK_EMIT && out_free) begin
				lag_q[0] <= x_q;
				for (int i = 1; i < MAX_ORDER; i++) begin
					lag_q[i] <= lag_q[i-1];
				end
				if (seen_q < ORD_W'(MAX_ORDER)) begin
					seen_q <= seen_q + 1'b1;
				end
			end
		end
	end

	// Tap products, one tap per cycle, floored to Q16.16.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= (state_q == BK_MAC);
		end
	end

	always_ff @(posedge clk) begin
		mprod_s1 <= mprod >>> FRAC_W;
		sprod_s1 <= $signed(sprod[ACC_W-1:0]) >>> FRAC_W;
	end

	// Sample datapath: sums, numerator and the staged result.
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				x_q        <= head.value;
				k_q        <= '0;
				macc_q     <= '0;
				sacc_q     <= ACC_W'(const_q);
				res_val_q  <= '0;
				res_warm_q <= 1'b1;
				res_bad_q  <= 1'b0;
				res_sat_q  <= 1'b0;
			end
			BK_MAC: begin
				k_q <= k_q + 1'b1;
			end
			BK_NUMER: begin
				neg_q      <= num[ACC_W-1];
				mag_q      <= num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
				res_warm_q <= 1'b0;
				res_bad_q  <= scale_bad;
			end
			BK_RANGE: begin
				if (too_big) begin
					res_val_q <= neg_q ? RES_NEG_MAX : RES_POS_MAX;
					res_sat_q <= 1'b1;
				end
			end
			BK_FINISH: begin
				if (div_rsp.quo > limit) begin
					res_val_q <= neg_q ? RES_NEG_MAX : RES_POS_MAX;
					res_sat_q <= 1'b1;
				end else begin
					res_val_q <= neg_q ? (VALUE_W'(0) - div_rsp.quo[VALUE_W-1:0])
						: div_rsp.quo[VALUE_W-1:0];
				end
			end
			default: begin
			end
		endcase
		if (prod_vld_s1) begin
			macc_q <= macc_q + mprod_s1;
			sacc_q <= sacc_q + sprod_s1;
		end
	end

	// Result register; it takes the next result when empty or as the current one is popped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == BK_EMIT && out_free) begin
			out_vld_q <= 1'b1;
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_EMIT && out_free) begin
			out_res_q  <= res_val_q;
			out_warm_q <= res_warm_q;
			out_bad_q  <= res_bad_q;
			out_sat_q  <= res_sat_q;
		end
	end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the residual filter core: directed and random item streams.
module tb_top;
	import rdf_pkg::*;

	// Table layout and kinds of input beats.
	localparam int MAX_TAPS    = MAX_ORDER_DEF;
	localparam int CONST_SLOT  = MAX_TAPS;
	localparam int SCALE_BASE  = MAX_TAPS + 1;
	localparam int TABLE_SIZE  = 2 * MAX_TAPS + 1;
	localparam logic KIND_COEF   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;
	localparam logic [PADDR_W-1:0] ORDER_ADDR = PADDR_W'(4 * REG_MODEL_ORDER);

	// Q16.16 constants used by the stimulus and the limits of the result.
	localparam logic signed [VALUE_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VALUE_W-1:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] Q_ONE = 32'sh0001_0000;
	localparam int ONE_INT = 65536;
	localparam logic [VALUE_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
	localparam logic [VALUE_W-1:0] NEG_LIMIT = 32'h8000_0000;

	// Cycles allowed for a trailing coefficient beat after the last result.
	localparam int DRAIN_CYCLES = 100;
	localparam int CLK_HALF     = 6;
	localparam int RUN_LIMIT    = 12_000_000;

	// Shapes of coefficient sets used by the random streams.
	typedef enum int {
		W_TYPICAL,
		W_NEG_SCALE,
		W_TINY_SCALE,
		W_WILD
	} weight_profile_t;

	// One result beat as predicted.
	typedef struct packed {
		logic signed [VALUE_W-1:0] residual;
		logic                      warming_up;
		logic                      bad_scale;
		logic                      saturated;
	} residual_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic kind;
	logic [SLOT_W-1:0] coef_slot;
	logic signed [VALUE_W-1:0] value;
	logic empty;
	logic pop;
	logic signed [VALUE_W-1:0] residual;
	logic warming_up;
	logic bad_scale;
	logic saturated;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	// Predictor state.
	logic signed [VALUE_W-1:0] lag_hist [MAX_TAPS];
	logic signed [VALUE_W-1:0] weight_tbl [TABLE_SIZE];
	int unsigned seen_count;
	logic [CFG_ORDER_W-1:0] order_reg;

	residual_t pending_results [$];
	int mismatch_count;
	int result_hold_cycles;
	bit no_idle;

	ldar_residual_filter_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.coef_slot  (coef_slot),
		.value      (value),
		.empty      (empty),
		.pop        (pop),
		.residual   (residual),
		.warming_up (warming_up),
		.bad_scale  (bad_scale),
		.saturated  (saturated),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#RUN_LIMIT;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= 50) begin
			$display("mismatch in %s at %0t: got %h, expected %h", what, $realtime, got, want);
		end
	endtask

	// Predicts the result of one sample and advances the lag history.
	function automatic residual_t predict_residual(input logic signed [VALUE_W-1:0] x);
		residual_t r;
		int unsigned taps;
		int k;
		longint loc_sum;
		longint scale_sum;
		longint numer;
		longint mag_abs;
		longint lag_abs;
		logic [95:0] quot;
		logic [VALUE_W-1:0] lim;
		logic neg;
		r = '0;
		taps = (order_reg == 0) ? 1 : (order_reg > MAX_TAPS) ? MAX_TAPS : order_reg;
		if (seen_count < taps) begin
			r.warming_up = 1'b1;
		end else begin
			// Location and scale sums, each product floored to Q16.16.
			loc_sum = 0;
			scale_sum = longint'(weight_tbl[CONST_SLOT]);
			for (k = 0; k < taps; k++) begin
				lag_abs = (lag_hist[k] < 0) ? -longint'(lag_hist[k]) : longint'(lag_hist[k]);
				loc_sum += (longint'(weight_tbl[k]) * longint'(lag_hist[k])) >>> FRAC_W;
				scale_sum += (longint'(weight_tbl[SCALE_BASE + k]) * lag_abs) >>> FRAC_W;
			end
			if (scale_sum <= 0) begin
				r.bad_scale = 1'b1;
			end else begin
				// Magnitude quotient truncated toward zero, then clipped and signed.
				numer = longint'(x) - loc_sum;
				neg = (numer < 0);
				mag_abs = neg ? -numer : numer;
				quot = ({32'd0, mag_abs} << FRAC_W) / {32'd0, scale_sum};
				lim = neg ? NEG_LIMIT : POS_LIMIT;
				if (quot > {64'd0, lim}) begin
					quot = {64'd0, lim};
					r.saturated = 1'b1;
				end
				r.residual = neg ? -quot[VALUE_W-1:0] : quot[VALUE_W-1:0];
			end
		end
		for (k = MAX_TAPS - 1; k > 0; k--) begin
			lag_hist[k] = lag_hist[k - 1];
		end
		lag_hist[0] = x;
		if (seen_count < MAX_TAPS) begin
			seen_count++;
		end
		return r;
	endfunction

	// Updates the predictor for one accepted input beat.
	task automatic apply_item(input logic k, input logic [SLOT_W-1:0] slot,
			input logic signed [VALUE_W-1:0] v);
		if (k == KIND_COEF) begin
			if (slot < TABLE_SIZE) begin
				weight_tbl[slot] = v;
			end
		end else begin
			pending_results.push_back(predict_residual(v));
		end
	endtask

	// Offers one input beat after a random gap and waits until it is taken.
	task automatic send_item(input logic k, input logic [SLOT_W-1:0] slot,
			input logic signed [VALUE_W-1:0] v);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		kind <= k;
		coef_slot <= slot;
		value <= v;
		do @(posedge clk); while (full);
		apply_item(k, slot, v);
	endtask

	task automatic send_sample(input logic signed [VALUE_W-1:0] v);
		send_item(KIND_SAMPLE, SLOT_W'($urandom()), v);
	endtask

	// Stops offering beats and waits until the block has gone idle.
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic read_order(output logic [PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ORDER_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Writes model_order and reads it back.
	task automatic write_order(input logic [PDATA_W-1:0] data);
		logic [PDATA_W-1:0] rd;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ORDER_ADDR;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		order_reg = data[CFG_ORDER_W-1:0];
		@(posedge clk);
		read_order(rd);
		if (rd !== PDATA_W'(order_reg)) begin
			report_mismatch("model_order readback", rd, PDATA_W'(order_reg));
		end
	endtask

	function automatic logic signed [VALUE_W-1:0] rand_fixed(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_sample();
		case ($urandom_range(0, 15))
			0: return $urandom();
			1: begin
				case ($urandom_range(0, 3))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return '0;
					default: return -1;
				endcase
			end
			default: return rand_fixed(8 * ONE_INT);
		endcase
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_weight(input weight_profile_t prof,
			input int slot);
		if (prof == W_WILD) begin
			return $urandom();
		end
		if (slot < CONST_SLOT) begin
			return rand_fixed(ONE_INT);
		end
		if (slot == CONST_SLOT) begin
			case (prof)
				W_NEG_SCALE: return -int'($urandom_range(0, 2 * ONE_INT));
				W_TINY_SCALE: return $urandom_range(0, 3);
				default: return 32'h4000 + $urandom_range(0, 4 * ONE_INT);
			endcase
		end
		case (prof)
			W_NEG_SCALE: return rand_fixed(ONE_INT);
			W_TINY_SCALE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 0;
			default: return $urandom_range(0, ONE_INT);
		endcase
	endfunction

	task automatic load_weights(input weight_profile_t prof);
		int s;
		for (s = 0; s < TABLE_SIZE; s++) begin
			send_item(KIND_COEF, SLOT_W'(s), pick_weight(prof, s));
		end
	endtask

	// Reset value of the register, then warm-up and a zero scale from the empty table.
	task automatic test_reset_state();
		logic [PDATA_W-1:0] rd;
		read_order(rd);
		if (rd !== PDATA_W'(ORDER_RESET)) begin
			report_mismatch("model_order after reset", rd, PDATA_W'(ORDER_RESET));
		end
		send_sample(Q_MAX);
		send_sample(Q_MIN);
		send_sample('0);
	endtask

	// Raising the order brings warm-up back; orders of zero and above the top clamp.
	task automatic test_warmup_and_order();
		settle();
		write_order(6);
		repeat (4) send_sample(rand_fixed(4 * ONE_INT));
		settle();
		write_order(0);
		send_sample(Q_ONE);
		settle();
		write_order(15);
		send_sample(-Q_ONE);
	endtask

	// Table writes, ignored slots, both saturations and a negative scale.
	task automatic test_table_and_limits();
		settle();
		write_order(1);
		send_item(KIND_COEF, 5'd0, 32'sh0000_8000);
		send_item(KIND_COEF, SLOT_W'(CONST_SLOT), Q_ONE);
		send_item(KIND_COEF, SLOT_W'(SCALE_BASE), 32'sh0000_4000);
		send_item(KIND_COEF, 5'd17, 32'shFFFF_FFFF);
		send_item(KIND_COEF, 5'd31, Q_MIN);
		send_sample(32'sh0002_0000);
		send_sample(-32'sh0003_0000);
		// Tiny scale with no scale lag weight: both signs clip.
		send_item(KIND_COEF, SLOT_W'(CONST_SLOT), 32'sd1);
		send_item(KIND_COEF, SLOT_W'(SCALE_BASE), '0);
		send_sample(Q_MAX);
		send_sample(Q_MIN);
		send_item(KIND_COEF, SLOT_W'(CONST_SLOT), -Q_ONE);
		send_sample(Q_ONE);
	endtask

	// Streams of samples under several orders and coefficient sets.
	task automatic test_random_streams();
		int unsigned orders [6] = '{1, 8, 3, 0, 15, 5};
		weight_profile_t profs [6] = '{W_TYPICAL, W_TYPICAL, W_NEG_SCALE, W_TINY_SCALE,
			W_WILD, W_TYPICAL};
		int ph;
		int n;
		for (ph = 0; ph < 6; ph++) begin
			settle();
			write_order({28'($urandom()), 4'(orders[ph])});
			load_weights(profs[ph]);
			for (n = 0; n < 75; n++) begin
				if ($urandom_range(0, 19) == 0) begin
					send_item(KIND_COEF, SLOT_W'($urandom()),
						pick_weight(profs[ph], $urandom_range(0, 31)));
				end else begin
					send_sample(pick_sample());
				end
			end
		end
	endtask

	// The result side holds off long enough for the block to stall its input.
	task automatic test_output_backpressure();
		settle();
		write_order(4);
		load_weights(W_TYPICAL);
		result_hold_cycles = 400;
		repeat (20) send_sample(pick_sample());
	endtask

	// Both sides run without gaps.
	task automatic test_back_to_back();
		int n;
		settle();
		write_order(8);
		no_idle = 1'b1;
		load_weights(W_TYPICAL);
		for (n = 0; n < 40; n++) begin
			if (n % 10 == 9) begin
				send_item(KIND_COEF, SLOT_W'($urandom_range(0, TABLE_SIZE - 1)),
					pick_weight(W_TYPICAL, $urandom_range(0, TABLE_SIZE - 1)));
			end else begin
				send_sample(pick_sample());
			end
		end
		settle();
		no_idle = 1'b0;
	endtask

	// Result side: takes each beat after a random stall, or a long hold when asked.
	initial begin : result_drain
		int stall;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (result_hold_cycles > 0) begin
				pop <= 1'b0;
				repeat (result_hold_cycles) @(posedge clk);
				result_hold_cycles = 0;
			end
			stall = no_idle ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	// Compares every accepted result beat with the oldest prediction.
	always @(posedge clk) begin : check_results
		residual_t want;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", residual, '0);
			end else begin
				want = pending_results.pop_front();
				if (residual !== want.residual) begin
					report_mismatch("residual", residual, want.residual);
				end
				if (warming_up !== want.warming_up) begin
					report_mismatch("warming_up", 32'(warming_up), 32'(want.warming_up));
				end
				if (bad_scale !== want.bad_scale) begin
					report_mismatch("bad_scale", 32'(bad_scale), 32'(want.bad_scale));
				end
				if (saturated !== want.saturated) begin
					report_mismatch("saturated", 32'(saturated), 32'(want.saturated));
				end
			end
		end
	end

	// Reset, run the tests in turn, and give the verdict.
	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		kind <= KIND_COEF;
		coef_slot <= '0;
		value <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		for (int k = 0; k < MAX_TAPS; k++) lag_hist[k] = '0;
		for (int k = 0; k < TABLE_SIZE; k++) weight_tbl[k] = '0;
		seen_count = 0;
		order_reg = ORDER_RESET;
		mismatch_count = 0;
		result_hold_cycles = 0;
		no_idle = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_warmup_and_order();
		test_table_and_limits();
		test_random_streams();
		test_output_backpressure();
		test_back_to_back();
		settle();

		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
